/* rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, types and sideband structs shared by the matrix-to-quaternion
// pipeline stages.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int WORD_BITS = 16;
	localparam int FRAC_BITS = 14;
	localparam int FX_ONE    = 1 << FRAC_BITS;
	localparam int WORD_MAX  = (1 << (WORD_BITS - 1)) - 1;

	// numerators: sum or difference of two words, plus trace and u widths
	localparam int AN_BITS   = WORD_BITS + 2;
	localparam int MAG_BITS  = WORD_BITS + 1;
	localparam int TR_BITS   = WORD_BITS + 2;
	localparam int UF_BITS   = WORD_BITS + 4;
	localparam int U_BITS    = WORD_BITS + 1;

	// determinant
	localparam int DP_BITS   = 2 * WORD_BITS;
	localparam int DC_BITS   = 2 * WORD_BITS + 1;
	localparam int DT_BITS   = 3 * WORD_BITS + 1;
	localparam int DS_BITS   = 3 * WORD_BITS + 3;

	// square root: radicand u * ONE, two result bits per stage
	localparam int STEPS       = 2;
	localparam int RAD_BITS    = ((U_BITS + FRAC_BITS + 1) / 2) * 2;
	localparam int ROOT_BITS   = RAD_BITS / 2;
	localparam int SQ_REM_BITS = ROOT_BITS + 3;
	localparam int SQ_STAGES   = ROOT_BITS / STEPS;

	// division: (|a| * ONE + s) / (2 s), two quotient bits per stage
	localparam int DEN_BITS    = ROOT_BITS + 1;
	localparam int NUM_BITS    = MAG_BITS + FRAC_BITS;
	localparam int QUO_BITS    = ROOT_BITS;
	localparam int DIV_STAGES  = QUO_BITS / STEPS;

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic       refl;
		logic       pos;
		axis_t      axis;
		logic [2:0] neg;
	} tag_t;

	typedef struct packed {
		tag_t                           tag;
		logic [2:0][MAG_BITS-1:0]       mag;
		logic [RAD_BITS-1:0]            rad;
		logic [SQ_REM_BITS-1:0]         rem;
		logic [ROOT_BITS-1:0]           root;
	} sq_t;

	typedef struct packed {
		tag_t                           tag;
		logic [ROOT_BITS-1:0]           root;
		logic [2:0][DEN_BITS-1:0]       rem;
		logic [2:0][QUO_BITS-1:0]       low;
		logic [2:0][QUO_BITS-1:0]       quo;
	} div_t;

endpackage

/* rtl/rmq_mat_if.sv */
// ----------------------------------------------------------------------------
// rmq_mat_if
// Matrix channel: nine signed elements per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmq_mat_if import rmq_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t m00, m01, m02;
	word_t m10, m11, m12;
	word_t m20, m21, m22;

	modport source (
		output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input  ready
	);
	modport sink (
		input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready
	);
endinterface

/* rtl/rmq_quat_if.sv */
// ----------------------------------------------------------------------------
// rmq_quat_if
// Quaternion channel: four signed components and a reflection flag per beat.
// ----------------------------------------------------------------------------
interface rmq_quat_if import rmq_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t qx, qy, qz, qw;
	logic  reflected;

	modport source (
		output valid, qx, qy, qz, qw, reflected,
		input  ready
	);
	modport sink (
		input  valid, qx, qy, qz, qw, reflected,
		output ready
	);
endinterface

/* rtl/rmq_sqrt_stage.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt_stage
// One registered stage of the digit-by-digit square root, two root bits.
// ----------------------------------------------------------------------------
module rmq_sqrt_stage import rmq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic prev_valid,
	input  sq_t  prev,
	output logic valid,
	output sq_t  data
);

	logic                   valid_s1;
	sq_t                    data_s1;
	sq_t                    nxt;
	logic [SQ_REM_BITS-1:0] rem;
	logic [SQ_REM_BITS-1:0] sh;
	logic [SQ_REM_BITS-1:0] trial;
	logic [ROOT_BITS-1:0]   root;
	logic [RAD_BITS-1:0]    rad;

	always_comb begin
		nxt  = prev;
		rem  = prev.rem;
		root = prev.root;
		rad  = prev.rad;
		sh   = '0;
		trial = '0;
		for (int k = 0; k < STEPS; k++) begin
			// bring down the next radicand pair
			sh    = {rem[SQ_REM_BITS-3:0], rad[RAD_BITS-1 -: 2]};
			rad   = {rad[RAD_BITS-3:0], 2'b00};
			trial = SQ_REM_BITS'({root, 2'b01});
			if (sh >= trial) begin
				rem  = sh - trial;
				root = {root[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem  = sh;
				root = {root[ROOT_BITS-2:0], 1'b0};
			end
		end
		nxt.rem  = rem;
		nxt.root = root;
		nxt.rad  = rad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= nxt;
		end
	end

	assign valid = valid_s1;
	assign data  = data_s1;

endmodule

/* rtl/rmq_div_stage.sv */
// ----------------------------------------------------------------------------
// rmq_div_stage
// One registered stage of three restoring dividers sharing the divisor 2s,
// two quotient bits per lane.
// ----------------------------------------------------------------------------
module rmq_div_stage import rmq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic prev_valid,
	input  div_t prev,
	output logic valid,
	output div_t data
);

	logic                 valid_s1;
	div_t                 data_s1;
	div_t                 nxt;
	logic [DEN_BITS-1:0]  den;
	logic [DEN_BITS-1:0]  rem;
	logic [DEN_BITS:0]    sh;
	logic [QUO_BITS-1:0]  low;
	logic [QUO_BITS-1:0]  quo;

	always_comb begin
		nxt = prev;
		den = {prev.root, 1'b0};
		rem = '0;
		sh  = '0;
		low = '0;
		quo = '0;
		for (int l = 0; l < 3; l++) begin
			rem = prev.rem[l];
			low = prev.low[l];
			quo = prev.quo[l];
			for (int k = 0; k < STEPS; k++) begin
				sh  = {rem, low[QUO_BITS-1]};
				low = {low[QUO_BITS-2:0], 1'b0};
				if (sh >= {1'b0, den}) begin
					rem = DEN_BITS'(sh - {1'b0, den});
					quo = {quo[QUO_BITS-2:0], 1'b1};
				end else begin
					rem = sh[DEN_BITS-1:0];
					quo = {quo[QUO_BITS-2:0], 1'b0};
				end
			end
			nxt.rem[l] = rem;
			nxt.low[l] = low;
			nxt.quo[l] = quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= nxt;
		end
	end

	assign valid = valid_s1;
	assign data  = data_s1;

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix (Q1.14) to unit quaternion, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | dir | beat payload                         | handshake
//  mat     | in  | m00..m22, signed Q1.14               | valid/ready
//  quat    | out | qx, qy, qz, qw Q1.14, reflected flag | valid/ready
//
//  One matrix per cycle while quat is not stalled, through three front stages
//  (element products, determinant terms, determinant sign), eight root
//  stages, eight divider stages and the output register.
//  Reset clears only the stage valid bits. Each stage holds while its
//  successor is full and stalled, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rmq_mat_if.sink     mat,
	rmq_quat_if.source  quat
);

	// ---------------- front stage combinational ----------------
	logic signed [TR_BITS-1:0]  trace;
	logic signed [UF_BITS-1:0]  u_full;
	logic signed [AN_BITS-1:0]  a [3];
	logic                       pos;
	axis_t                      axis;
	word_t                      diag;
	sq_t                        front;
	logic signed [DP_BITS-1:0]  prod [6];

	always_comb begin
		trace = TR_BITS'(mat.m00) + TR_BITS'(mat.m11) + TR_BITS'(mat.m22);
		pos   = trace > 0;
		axis  = AXIS_X;
		diag  = mat.m00;
		if (mat.m11 > mat.m00) begin
			axis = AXIS_Y;
			diag = mat.m11;
		end
		if (mat.m22 > diag) begin
			axis = AXIS_Z;
			diag = mat.m22;
		end
		if (pos) begin
			u_full = UF_BITS'(trace) + UF_BITS'(FX_ONE);
			a[0] = AN_BITS'(mat.m21) - AN_BITS'(mat.m12);
			a[1] = AN_BITS'(mat.m02) - AN_BITS'(mat.m20);
			a[2] = AN_BITS'(mat.m10) - AN_BITS'(mat.m01);
		end else begin
			u_full = UF_BITS'(FX_ONE) + (UF_BITS'(diag) <<< 1) - UF_BITS'(trace);
			case (axis)
				AXIS_Y: begin
					a[0] = AN_BITS'(mat.m02) - AN_BITS'(mat.m20);
					a[1] = AN_BITS'(mat.m21) + AN_BITS'(mat.m12);
					a[2] = AN_BITS'(mat.m01) + AN_BITS'(mat.m10);
				end
				AXIS_Z: begin
					a[0] = AN_BITS'(mat.m10) - AN_BITS'(mat.m01);
					a[1] = AN_BITS'(mat.m02) + AN_BITS'(mat.m20);
					a[2] = AN_BITS'(mat.m12) + AN_BITS'(mat.m21);
				end
				default: begin
					a[0] = AN_BITS'(mat.m21) - AN_BITS'(mat.m12);
					a[1] = AN_BITS'(mat.m10) + AN_BITS'(mat.m01);
					a[2] = AN_BITS'(mat.m20) + AN_BITS'(mat.m02);
				end
			endcase
		end
		front = '0;
		front.tag.pos  = pos;
		front.tag.axis = axis;
		for (int l = 0; l < 3; l++) begin
			front.tag.neg[l] = a[l][AN_BITS-1];
			front.mag[l] = a[l][AN_BITS-1] ? MAG_BITS'(-a[l]) : MAG_BITS'(a[l]);
		end
		// u is at least ONE on either branch, so the low bits hold it exactly
		front.rad = RAD_BITS'({u_full[U_BITS-1:0], {FRAC_BITS{1'b0}}});

		prod[0] = mat.m11 * mat.m22;
		prod[1] = mat.m12 * mat.m21;
		prod[2] = mat.m12 * mat.m20;
		prod[3] = mat.m10 * mat.m22;
		prod[4] = mat.m10 * mat.m21;
		prod[5] = mat.m11 * mat.m20;
	end

	// ---------------- stage control ----------------
	logic valid_s1, valid_s2, valid_s3, valid_s20;
	logic go1, go2, go3, go_out;
	logic sq_valid [SQ_STAGES+1];
	sq_t  sq_data  [SQ_STAGES+1];
	logic sq_go    [SQ_STAGES+1];
	logic dv_valid [DIV_STAGES+1];
	div_t dv_data  [DIV_STAGES+1];
	logic dv_go    [DIV_STAGES+1];

	assign go_out = !valid_s20 || quat.ready;
	assign dv_go[DIV_STAGES] = go_out;
	assign sq_go[SQ_STAGES]  = dv_go[0];
	assign go3 = !valid_s3 || sq_go[0];
	assign go2 = !valid_s2 || go3;
	assign go1 = !valid_s1 || go2;
	assign mat.ready = go1;

	// ---------------- front pipeline registers ----------------
	sq_t                       sq_s1, sq_s2, sq_s3;
	sq_t                       sq_det;
	logic signed [DP_BITS-1:0] prod_s1 [6];
	word_t                     m00_s1, m01_s1, m02_s1;
	logic signed [DT_BITS-1:0] term_s2 [3];
	logic signed [DC_BITS-1:0] cof [3];
	logic signed [DS_BITS-1:0] det;

	always_comb begin
		cof[0] = DC_BITS'(prod_s1[0]) - DC_BITS'(prod_s1[1]);
		cof[1] = DC_BITS'(prod_s1[2]) - DC_BITS'(prod_s1[3]);
		cof[2] = DC_BITS'(prod_s1[4]) - DC_BITS'(prod_s1[5]);
		det = DS_BITS'(term_s2[0]) + DS_BITS'(term_s2[1]) + DS_BITS'(term_s2[2]);
		sq_det          = sq_s2;
		sq_det.tag.refl = det[DS_BITS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (go1) valid_s1 <= mat.valid;
			if (go2) valid_s2 <= valid_s1;
			if (go3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			sq_s1   <= front;
			prod_s1 <= prod;
			m00_s1  <= mat.m00;
			m01_s1  <= mat.m01;
			m02_s1  <= mat.m02;
		end
		if (go2) begin
			sq_s2      <= sq_s1;
			term_s2[0] <= m00_s1 * cof[0];
			term_s2[1] <= m01_s1 * cof[1];
			term_s2[2] <= m02_s1 * cof[2];
		end
		if (go3) begin
			sq_s3 <= sq_det;
		end
	end

	// ---------------- square root stages ----------------
	assign sq_valid[0] = valid_s3;
	assign sq_data[0]  = sq_s3;

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		assign sq_go[k] = !sq_valid[k+1] || sq_go[k+1];
		rmq_sqrt_stage u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (sq_go[k]),
			.prev_valid (sq_valid[k]),
			.prev       (sq_data[k]),
			.valid      (sq_valid[k+1]),
			.data       (sq_data[k+1])
		);
	end

	// ---------------- divider setup and stages ----------------
	sq_t                 sq_last;
	div_t                dv_init;
	logic [NUM_BITS-1:0] num;

	always_comb begin
		sq_last      = sq_data[SQ_STAGES];
		dv_init      = '0;
		dv_init.tag  = sq_last.tag;
		dv_init.root = sq_last.root;
		num          = '0;
		for (int l = 0; l < 3; l++) begin
			// add s so the floor quotient rounds half away from zero
			num = NUM_BITS'({sq_last.mag[l], {FRAC_BITS{1'b0}}})
				+ NUM_BITS'(sq_last.root);
			dv_init.rem[l] = DEN_BITS'(num[NUM_BITS-1:QUO_BITS]);
			dv_init.low[l] = num[QUO_BITS-1:0];
		end
	end

	assign dv_valid[0] = sq_valid[SQ_STAGES];
	assign dv_data[0]  = dv_init;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		assign dv_go[k] = !dv_valid[k+1] || dv_go[k+1];
		rmq_div_stage u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (dv_go[k]),
			.prev_valid (dv_valid[k]),
			.prev       (dv_data[k]),
			.valid      (dv_valid[k+1]),
			.data       (dv_data[k+1])
		);
	end

	// ---------------- output stage ----------------
	div_t                      dv_last;
	logic signed [QUO_BITS:0]  sv;
	word_t                     lane [3];
	word_t                     half;
	word_t                     qx_n, qy_n, qz_n, qw_n;
	word_t                     qx_s20, qy_s20, qz_s20, qw_s20;
	logic                      refl_s20;

	always_comb begin
		dv_last = dv_data[DIV_STAGES];
		sv = '0;
		for (int l = 0; l < 3; l++) begin
			sv = dv_last.tag.neg[l] ? -$signed({1'b0, dv_last.quo[l]})
				: $signed({1'b0, dv_last.quo[l]});
			// saturate the positive end only
			if (sv > $signed((QUO_BITS+1)'(WORD_MAX))) begin
				lane[l] = word_t'(WORD_MAX);
			end else begin
				lane[l] = WORD_BITS'(sv);
			end
		end
		half = WORD_BITS'(dv_last.root[ROOT_BITS-1:1]);
		qx_n = '0;
		qy_n = '0;
		qz_n = '0;
		qw_n = '0;
		if (!dv_last.tag.refl) begin
			if (dv_last.tag.pos) begin
				qx_n = lane[0];
				qy_n = lane[1];
				qz_n = lane[2];
				qw_n = half;
			end else begin
				qw_n = lane[0];
				case (dv_last.tag.axis)
					AXIS_Y: begin
						qy_n = half;
						qz_n = lane[1];
						qx_n = lane[2];
					end
					AXIS_Z: begin
						qz_n = half;
						qx_n = lane[1];
						qy_n = lane[2];
					end
					default: begin
						qx_n = half;
						qy_n = lane[1];
						qz_n = lane[2];
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s20 <= 1'b0;
		end else if (go_out) begin
			valid_s20 <= dv_valid[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (go_out) begin
			qx_s20   <= qx_n;
			qy_s20   <= qy_n;
			qz_s20   <= qz_n;
			qw_s20   <= qw_n;
			refl_s20 <= dv_last.tag.refl;
		end
	end

	assign quat.valid     = valid_s20;
	assign quat.qx        = qx_s20;
	assign quat.qy        = qy_s20;
	assign quat.qz        = qz_s20;
	assign quat.qw        = qw_s20;
	assign quat.reflected = refl_s20;

endmodule

/* dv/rotation_matrix_to_quaternion_test.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Feeds matrices through the converter with random gaps on both channels and
// checks every quaternion against a fixed-point Shoemake predictor.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test import rmq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		longint qx, qy, qz, qw;
		bit     reflected;
	} quat_exp_t;

	class quat_scoreboard;
		quat_exp_t pending[$];
		int        errors;

		static function longint isqrt(longint v);
			longint r, b;
			r = 0;
			b = 64'sd1 << 62;
			while (b > v) b = b >>> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >>> 1) + b;
				end else begin
					r = r >>> 1;
				end
				b = b >>> 2;
			end
			return r;
		endfunction

		static function longint div_near(longint num, longint den);
			longint m, q;
			m = num < 0 ? -num : num;
			q = (m + den / 2) / den;
			return num < 0 ? -q : q;
		endfunction

		static function longint clamp(longint v);
			if (v > WORD_MAX) return WORD_MAX;
			if (v < -WORD_MAX - 1) return -WORD_MAX - 1;
			return v;
		endfunction

		function void note_matrix(word_t m[9]);
			longint e[3][3];
			longint q[4];
			longint det, tr, s, d;
			int i, j, k;
			quat_exp_t x;
			for (int n = 0; n < 9; n++) e[n / 3][n % 3] = m[n];
			q = '{0, 0, 0, 0};
			det = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
				+ e[0][1] * (e[1][2] * e[2][0] - e[1][0] * e[2][2])
				+ e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
			x.reflected = det < 0;
			if (!x.reflected) begin
				tr = e[0][0] + e[1][1] + e[2][2];
				if (tr > 0) begin
					s = isqrt((tr + FX_ONE) << FRAC_BITS);
					d = 2 * s;
					q[3] = s >>> 1;
					q[0] = div_near((e[2][1] - e[1][2]) * FX_ONE, d);
					q[1] = div_near((e[0][2] - e[2][0]) * FX_ONE, d);
					q[2] = div_near((e[1][0] - e[0][1]) * FX_ONE, d);
				end else begin
					i = 0;
					if (e[1][1] > e[0][0]) i = 1;
					if (e[2][2] > e[i][i]) i = 2;
					j = (i + 1) % 3;
					k = (j + 1) % 3;
					s = isqrt((FX_ONE + e[i][i] - e[j][j] - e[k][k]) << FRAC_BITS);
					d = 2 * s;
					q[i] = s >>> 1;
					q[3] = div_near((e[k][j] - e[j][k]) * FX_ONE, d);
					q[j] = div_near((e[j][i] + e[i][j]) * FX_ONE, d);
					q[k] = div_near((e[k][i] + e[i][k]) * FX_ONE, d);
				end
			end
			x.qx = clamp(q[0]);
			x.qy = clamp(q[1]);
			x.qz = clamp(q[2]);
			x.qw = clamp(q[3]);
			pending.push_back(x);
		endfunction

		function void check_quat(word_t qx, word_t qy, word_t qz, word_t qw, logic refl);
			quat_exp_t x;
			if (pending.size() == 0) begin
				$error("unexpected quaternion beat");
				errors++;
				return;
			end
			x = pending.pop_front();
			if (qx !== x.qx) begin $error("qx exp %0d got %0d", x.qx, qx); errors++; end
			if (qy !== x.qy) begin $error("qy exp %0d got %0d", x.qy, qy); errors++; end
			if (qz !== x.qz) begin $error("qz exp %0d got %0d", x.qz, qz); errors++; end
			if (qw !== x.qw) begin $error("qw exp %0d got %0d", x.qw, qw); errors++; end
			if (refl !== x.reflected) begin
				$error("reflected exp %0d got %0d", x.reflected, refl);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	rmq_mat_if  mat();
	rmq_quat_if quat();
	quat_scoreboard quats = new();
	bit feed_done = 0;

	rotation_matrix_to_quaternion u_top (.clk(clk), .arst_n(arst_n), .mat(mat), .quat(quat));

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic word_t rand_elem();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sd16384;
			3: return -16'sd16384;
			4: return 0;
			5, 6: return word_t'($urandom_range(0, 32768) - 16384);
			default: return word_t'($urandom);
		endcase
	endfunction

	// Q1.14 rotation built from a random unit quaternion
	function automatic void rand_rotation(output word_t m[9]);
		real a, b, c, d, n;
		real r[9];
		a = $urandom_range(0, 2000) - 1000.0;
		b = $urandom_range(0, 2000) - 1000.0;
		c = $urandom_range(0, 2000) - 1000.0;
		d = $urandom_range(0, 2000) - 1000.0;
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 1.0) begin a = 1.0; n = 1.0; end
		a /= n; b /= n; c /= n; d /= n;
		r[0] = 1 - 2 * (c * c + d * d); r[1] = 2 * (b * c - a * d); r[2] = 2 * (b * d + a * c);
		r[3] = 2 * (b * c + a * d); r[4] = 1 - 2 * (b * b + d * d); r[5] = 2 * (c * d - a * b);
		r[6] = 2 * (b * d - a * c); r[7] = 2 * (c * d + a * b); r[8] = 1 - 2 * (b * b + c * c);
		for (int i = 0; i < 9; i++) m[i] = word_t'($rtoi(r[i] * 16384.0 + $urandom_range(0, 6) - 3.0));
	endfunction

	// drop valid only for a gap, so a held beat is never offered twice
	task automatic send_matrix(word_t m[9]);
		int g;
		g = gap_len();
		if (g > 0) begin
			mat.valid <= 0;
			repeat (g) @(posedge clk);
		end
		mat.valid <= 1;
		{mat.m00, mat.m01, mat.m02} <= {m[0], m[1], m[2]};
		{mat.m10, mat.m11, mat.m12} <= {m[3], m[4], m[5]};
		{mat.m20, mat.m21, mat.m22} <= {m[6], m[7], m[8]};
		do @(posedge clk); while (!mat.ready);
		quats.note_matrix(m);
	endtask

	task automatic send_diag(int a, int b, int c);
		word_t m[9];
		m = '{word_t'(a), 0, 0, 0, word_t'(b), 0, 0, 0, word_t'(c)};
		send_matrix(m);
	endtask

	initial begin
		word_t m[9];
		int r;
		mat.valid = 0;
		{mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22} = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// identity, half turns about each axis, ties, reflection, singular
		send_diag(16384, 16384, 16384);
		send_diag(16384, -16384, -16384);
		send_diag(-16384, 16384, -16384);
		send_diag(-16384, -16384, 16384);
		send_diag(0, 0, 0);
		send_diag(-16384, -16384, -16384);
		send_diag(16384, 16384, -16384);
		send_diag(0, 0, 16384);
		send_diag(-100, -100, 50);
		send_diag(-8192, -8192, -8192);
		send_diag(32767, 32767, 32767);
		send_diag(-32768, -32768, -32768);
		send_diag(-32768, 32767, -32768);
		m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384};
		send_matrix(m);
		m = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
		send_matrix(m);
		m = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
		send_matrix(m);
		m = '{0, 32767, 0, -32768, 0, 32767, 0, -32768, -1};
		send_matrix(m);
		for (int n = 0; n < 1600; n++) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				rand_rotation(m);
				if (r == 0) for (int i = 0; i < 9; i += 4) m[i] = -m[i];
			end else begin
				for (int i = 0; i < 9; i++) m[i] = rand_elem();
			end
			send_matrix(m);
			if (n == 800) begin
				mat.valid <= 0;
				wait (quats.pending.size() == 0);
				@(posedge clk);
			end
		end
		mat.valid <= 0;
		feed_done = 1;
	end

	// output stall pattern: random gaps with long stretches held ready
	initial begin
		int g;
		quat.ready = 0;
		@(posedge arst_n);
		forever begin
			quat.ready <= 1;
			do @(posedge clk); while ($urandom_range(0, 15) != 0);
			g = gap_len();
			if (g > 0) begin
				quat.ready <= 0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && quat.valid && quat.ready)
			quats.check_quat(quat.qx, quat.qy, quat.qz, quat.qw, quat.reflected);
	end

	initial begin
		wait (feed_done);
		wait (quats.pending.size() == 0);
		repeat (40) @(posedge clk);
		if (quats.errors == 0 && quats.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

/* files.f */
rtl/rmq_pkg.sv
rtl/rmq_mat_if.sv
rtl/rmq_quat_if.sv
rtl/rmq_sqrt_stage.sv
rtl/rmq_div_stage.sv
rtl/rotation_matrix_to_quaternion.sv
dv/rotation_matrix_to_quaternion_test.sv
